FILE: rtl/b64enc_pkg.sv
package b64enc_pkg;

    // Job queue between the byte front and the character back.
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [6:0] CHAR_PAD   = 7'h3D;  // '='
    localparam logic [6:0] CHAR_PLUS  = 7'h2B;  // '+'
    localparam logic [6:0] CHAR_SLASH = 7'h2F;  // '/'
    localparam logic [6:0] OFS_UPPER  = 7'd65;  // 'A'
    localparam logic [6:0] OFS_LOWER  = 7'd71;  // 'a' - 26
    localparam logic [6:0] OFS_DIGIT  = 7'd4;   // 52 - '0', subtracted

    localparam logic [1:0] PHASE_FIRST  = 2'd0;
    localparam logic [1:0] PHASE_SECOND = 2'd1;
    localparam logic [1:0] PHASE_THIRD  = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_in;

    typedef struct packed {
        logic [6:0] out_char;
        logic       last_char;
    } t_out;

    // One byte's worth of output characters, up to four.
    typedef struct packed {
        logic [3:0][5:0] sextet;
        logic [3:0]      pad;
        logic [1:0]      last_idx;
        logic            eom;
    } t_job;

    function automatic logic [6:0] sextet_char(input logic [5:0] v);
        logic [6:0] c;
        case (v) inside
            [6'd0:6'd25]:  c = 7'(v) + OFS_UPPER;
            [6'd26:6'd51]: c = 7'(v) + OFS_LOWER;
            [6'd52:6'd61]: c = 7'(v) - OFS_DIGIT;
            6'd62:         c = CHAR_PLUS;
            default:       c = CHAR_SLASH;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/b64enc_front.sv
module b64enc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  b64enc_pkg::t_in     i_in,
    input  logic                i_full,
    output logic                o_push,
    output b64enc_pkg::t_job    o_job
);
    import b64enc_pkg::*;

    logic [1:0] r_phase, n_phase;
    logic [3:0] r_left,  n_left;
    logic [7:0] b;
    logic       eom;

    assign b      = i_in.data_byte;
    assign eom    = i_in.end_of_message;
    assign o_push = i_valid && !i_full;

    always_comb begin
        o_job        = '0;
        o_job.eom    = eom;
        n_phase      = r_phase;
        n_left       = r_left;
        case (r_phase)
            PHASE_SECOND: begin
                o_job.sextet[0] = {r_left[1:0], b[7:4]};
                if (eom) begin
                    o_job.sextet[1] = {b[3:0], 2'b00};
                    o_job.pad[2]    = 1'b1;
                    o_job.last_idx  = 2'd2;
                end else begin
                    n_left  = b[3:0];
                    n_phase = PHASE_THIRD;
                end
            end
            PHASE_THIRD: begin
                o_job.sextet[0] = {r_left, b[7:6]};
                o_job.sextet[1] = b[5:0];
                o_job.last_idx  = 2'd1;
                n_left          = '0;
                n_phase         = PHASE_FIRST;
            end
            default: begin
                o_job.sextet[0] = b[7:2];
                if (eom) begin
                    o_job.sextet[1] = {b[1:0], 4'b0000};
                    o_job.pad[2]    = 1'b1;
                    o_job.pad[3]    = 1'b1;
                    o_job.last_idx  = 2'd3;
                end else begin
                    n_left  = {2'b00, b[1:0]};
                    n_phase = PHASE_SECOND;
                end
            end
        endcase
        if (eom) begin
            n_phase = PHASE_FIRST;
            n_left  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PHASE_FIRST;
            r_left  <= '0;
        end else if (o_push) begin
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

    // message end always returns to a clean group
    a_eom_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && eom) |=> (r_phase == PHASE_FIRST && r_left == '0))
        else $error("group state not cleared after last byte");

    // after the first byte only two leftover bits are live
    a_left_narrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PHASE_SECOND) |-> (r_left[3:2] == 2'b00))
        else $error("stray leftover bits in second phase");

endmodule

FILE: rtl/b64enc_queue.sv
module b64enc_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  b64enc_pkg::t_job    i_job,
    output logic                o_full,
    output logic                o_job_valid,
    input  logic                i_pop,
    output b64enc_pkg::t_job    o_job
);
    import b64enc_pkg::*;

    t_job           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QAW:0]   r_count;

    assign o_full      = (r_count == (QAW+1)'(QDEPTH));
    assign o_job_valid = (r_count != '0);
    assign o_job       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from empty job queue");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QAW+1)'(QDEPTH))
        else $error("job queue count beyond depth");

endmodule

FILE: rtl/b64enc_back.sv
module b64enc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  b64enc_pkg::t_job    i_job,
    output logic                o_pop,
    output logic                o_valid,
    output b64enc_pkg::t_out    o_out,
    input  logic                i_stall
);
    import b64enc_pkg::*;

    t_job       r_job;
    logic       r_busy;
    logic [1:0] r_idx;
    logic       xfer;
    logic       job_end;

    assign xfer    = r_busy && !i_stall;
    assign job_end = xfer && (r_idx == r_job.last_idx);
    assign o_pop   = i_job_valid && (!r_busy || job_end);
    assign o_valid = r_busy;

    always_comb begin
        o_out.out_char  = r_job.pad[r_idx] ? CHAR_PAD : sextet_char(r_job.sextet[r_idx]);
        o_out.last_char = r_job.eom && (r_idx == r_job.last_idx);
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (job_end) begin
            r_busy <= 1'b0;
        end else if (xfer) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= r_job.last_idx))
        else $error("character index past end of job");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && i_stall) |=> (r_busy && $stable(r_idx)))
        else $error("character advanced while stalled");

endmodule

FILE: rtl/base64_stream_encoder_unit.sv
// Streaming Base64 encoder, standard alphabet A-Z a-z 0-9 + / with '=' padding.
// Input channel: one raw byte per transfer (i_in.data_byte), with
//   i_in.end_of_message set on the last byte of a message. o_stall pushes back.
// Output channel: one 7-bit ASCII character per transfer (o_out.out_char);
//   o_out.last_char marks the final character of each encoded message.
// Per byte: the first, second and third byte of a group give 1, 1 and 2
//   characters; a last byte in the first slot gives 4, in the second slot 3.
// Path: a taken byte is written into the job queue, then loaded into the back
//   end's job register, which drives its first character onto o_out.
// Throughput: the back end sends one character per cycle while i_stall is low;
//   a group of three bytes makes four characters.
//   The front takes a byte every cycle until the 4-entry job queue fills.
// Reset (i_rst_n low, synchronous): queue emptied, group phase back to the
//   first byte, no character pending.
// Receiver stall: the current character holds; the queue absorbs up to four
//   bytes, then o_stall rises until the back end drains a job.
module base64_stream_encoder_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  b64enc_pkg::t_in     i_in,
    output logic                o_stall,
    output logic                o_valid,
    output b64enc_pkg::t_out    o_out,
    input  logic                i_stall
);
    import b64enc_pkg::*;

    t_job q_in_job;   // classified byte from the front
    t_job q_out_job;  // head of the queue
    logic q_push;
    logic q_full;
    logic q_job_valid;
    logic q_pop;

    assign o_stall = q_full;

    // front: tracks group phase and leftover bits, splits each byte into sextets
    b64enc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_in    (i_in),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_job   (q_in_job)
    );

    // decouples byte intake from character output
    b64enc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_job       (q_in_job),
        .o_full      (q_full),
        .o_job_valid (q_job_valid),
        .i_pop       (q_pop),
        .o_job       (q_out_job)
    );

    // back: serializes a job one character per transfer, maps to ASCII
    b64enc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_job_valid),
        .i_job       (q_out_job),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .o_out       (o_out),
        .i_stall     (i_stall)
    );

endmodule
